>>> hw/rtl/swl_pkg.sv
// Shared types and constants for the sliding-window-log rate limiter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package swl_pkg;

  localparam int UserSlotsDefault = 256;
  localparam int MaxDepthDefault  = 16;
  localparam int TimeBitsDefault  = 32;

  localparam logic [15:0] WindowReset  = 16'd5;
  localparam logic [4:0]  MaxReqReset  = 5'd3;
  localparam logic [15:0] IdleReset    = 16'd10;

  // register indexes on the configuration port
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_MAXREQ = 2'd1;
  localparam logic [1:0] REG_IDLE   = 2'd2;

  // operation codes of an input request
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_SWEEP   = 1'b1;

  // command kinds after classification
  localparam logic [1:0] CMD_REQ   = 2'd0;
  localparam logic [1:0] CMD_DROP  = 2'd1;
  localparam logic [1:0] CMD_SWEEP = 2'd2;

  typedef struct packed {
    logic        op;
    logic [7:0]  user_index;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic       allowed;
    logic [8:0] freed_users;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  user;
    logic [31:0] now_seconds;
  } cmd_t;

  typedef struct packed {
    logic [15:0] window_seconds;
    logic [4:0]  max_requests;
    logic [15:0] idle_timeout;
  } cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/swl_front.sv
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on swl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swl_front import swl_pkg::*; #(
  parameter int USER_SLOTS = UserSlotsDefault,
  parameter int TIME_BITS  = TimeBitsDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd
);

  localparam logic [31:0] NowMask = (TIME_BITS >= 32) ? 32'hFFFF_FFFF
                                                      : 32'((64'd1 << TIME_BITS) - 64'd1);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.user        = in_item.user_index;
    cmd_in.now_seconds = in_item.now_seconds & NowMask;
    if (in_item.op == OP_SWEEP) begin
      cmd_in.kind = CMD_SWEEP;
    end else if (17'(in_item.user_index) >= 17'(USER_SLOTS)) begin
      cmd_in.kind = CMD_DROP;
    end else begin
      cmd_in.kind = CMD_REQ;
    end
  end

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/swl_back.sv
// Back end: per-user ring memories, eviction sequencer, sweep walker and result register.
// Depends on swl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swl_back import swl_pkg::*; #(
  parameter int USER_SLOTS = UserSlotsDefault,
  parameter int MAX_DEPTH  = MaxDepthDefault,
  parameter int TIME_BITS  = TimeBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  input  wire cfg_t cfg,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);

  localparam int UW   = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int HW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW   = $clog2(MAX_DEPTH + 1);
  localparam int PW   = $clog2(2 * MAX_DEPTH) + 1;
  localparam int AW   = $clog2(USER_SLOTS * MAX_DEPTH) > 0 ? $clog2(USER_SLOTS * MAX_DEPTH) : 1;
  localparam int TB   = TIME_BITS;
  localparam int WW   = ((TB > 16) ? TB : 16) + 1;
  localparam int MW   = HW + CW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_META   = 3'd1;
  localparam logic [2:0] ST_EV_RD  = 3'd2;
  localparam logic [2:0] ST_EV_CHK = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_SWEEP  = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]      state;
  logic [UW-1:0]   user;
  logic [TB-1:0]   now;
  logic            now_gt_win;
  logic [WW-1:0]   thresh;
  logic [HW-1:0]   head;
  logic [CW-1:0]   count;
  logic [TB-1:0]   last;
  logic [AW-1:0]   base;
  logic [UW:0]     sw_idx;
  logic [UW-1:0]   chk_idx;
  logic            chk_vld;
  logic [8:0]      freed;
  logic            res_allowed;
  logic [USER_SLOTS-1:0] slot_valid;

  // memories
  logic [TB-1:0] last_mem  [USER_SLOTS];
  logic [MW-1:0] meta_mem  [USER_SLOTS];
  logic [TB-1:0] stamp_mem [USER_SLOTS * MAX_DEPTH];
  logic [TB-1:0] last_rdata;
  logic [MW-1:0] meta_rdata;
  logic [TB-1:0] stamp_rdata;

  logic [UW-1:0] slot_raddr;
  logic [AW-1:0] stamp_raddr;
  logic [AW-1:0] stamp_waddr;
  logic          stamp_we;
  logic          slot_we;
  logic [TB-1:0] last_wdata;
  logic [MW-1:0] meta_wdata;

  logic [UW-1:0] cmd_user;
  logic [TB-1:0] cmd_now;
  logic [WW-1:0] cmd_now_w;
  logic [WW-1:0] win_w;
  logic          stale;
  logic [HW-1:0] head_inc;
  logic [8:0]    limit;
  logic          full;
  logic [PW-1:0] pos_sum;
  logic [PW-1:0] pos_wrap;
  logic [CW-1:0] count_new;
  logic [TB-1:0] last_new;
  logic          sweep_idle;
  logic          out_free;

  assign cmd_user  = UW'(cmd.user);
  assign cmd_now   = TB'(cmd.now_seconds);
  assign cmd_now_w = WW'(cmd_now);
  assign win_w     = WW'(cfg.window_seconds);
  assign cmd_ready = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign slot_raddr  = (state == ST_SWEEP) ? sw_idx[UW-1:0] : cmd_user;
  assign stamp_raddr = base + AW'(head);

  always_comb begin
    stale    = now_gt_win && (WW'(stamp_rdata) < thresh);
    head_inc = (head == HW'(MAX_DEPTH - 1)) ? '0 : head + HW'(1);
    limit    = (9'(cfg.max_requests) > 9'(MAX_DEPTH)) ? 9'(MAX_DEPTH) : 9'(cfg.max_requests);
    full     = 9'(count) >= limit;
    pos_sum  = PW'(head) + PW'(count);
    pos_wrap = (pos_sum >= PW'(MAX_DEPTH)) ? pos_sum - PW'(MAX_DEPTH) : pos_sum;
    stamp_waddr = base + AW'(pos_wrap);
    count_new = full ? count : count + CW'(1);
    last_new  = (!full && (now > last)) ? now : last;
    stamp_we  = (state == ST_DECIDE) && !full;
    slot_we   = (state == ST_DECIDE);
    last_wdata = last_new;
    meta_wdata = {head, count_new};
    sweep_idle = slot_valid[chk_idx] && (last_rdata <= now) &&
                 (WW'(now - last_rdata) >= WW'(cfg.idle_timeout));
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      last_mem[user] <= last_wdata;
      meta_mem[user] <= meta_wdata;
    end
    last_rdata <= last_mem[slot_raddr];
    meta_rdata <= meta_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= now;
    end
    stamp_rdata <= stamp_mem[stamp_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        user       <= cmd_user;
        now        <= cmd_now;
        now_gt_win <= cmd_now_w > win_w;
        thresh     <= cmd_now_w - win_w;
        freed      <= '0;
        res_allowed <= 1'b0;
      end
      ST_META: begin
        if (slot_valid[user]) begin
          head  <= meta_rdata[MW-1:CW];
          count <= meta_rdata[CW-1:0];
          last  <= last_rdata;
        end else begin
          head  <= '0;
          count <= '0;
          last  <= now;
        end
        base <= AW'(user) * AW'(MAX_DEPTH);
      end
      ST_EV_CHK: begin
        if (stale) begin
          head  <= head_inc;
          count <= count - CW'(1);
        end
      end
      ST_DECIDE: begin
        res_allowed <= !full;
      end
      ST_SWEEP: begin
        if (chk_vld && sweep_idle && (freed != 9'h1FF)) begin
          freed <= freed + 9'd1;
        end
      end
      default: begin
      end
    endcase
    if (state == ST_OUT && out_free) begin
      out_item.allowed     <= res_allowed;
      out_item.freed_users <= freed;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      out_valid  <= 1'b0;
      sw_idx     <= '0;
      chk_idx    <= '0;
      chk_vld    <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          sw_idx  <= '0;
          chk_vld <= 1'b0;
          if (cmd_valid) begin
            case (cmd.kind)
              CMD_REQ:   state <= ST_META;
              CMD_SWEEP: state <= ST_SWEEP;
              default:   state <= ST_OUT;
            endcase
          end
        end
        ST_META: begin
          slot_valid[user] <= 1'b1;
          state <= ST_EV_RD;
        end
        ST_EV_RD: begin
          state <= (count != '0) ? ST_EV_CHK : ST_DECIDE;
        end
        ST_EV_CHK: begin
          state <= stale ? ST_EV_RD : ST_DECIDE;
        end
        ST_DECIDE: begin
          state <= ST_OUT;
        end
        ST_SWEEP: begin
          if (chk_vld && sweep_idle) begin
            slot_valid[chk_idx] <= 1'b0;
          end
          chk_idx <= sw_idx[UW-1:0];
          chk_vld <= sw_idx < (UW + 1)'(USER_SLOTS);
          if (sw_idx < (UW + 1)'(USER_SLOTS)) begin
            sw_idx <= sw_idx + (UW + 1)'(1);
          end else if (!chk_vld) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sliding_window_log_rate_limiter_unit.sv
// Sliding-window-log rate limiter. A request reads its slot, then examines stored stamps in turn
// (each evicted one and the first one kept) before its decision; a dropped out-of-table request
// goes straight to the result. A sweep walks every slot at one per cycle.
// The back end handles one item at a time; the two-entry queue accepts requests while it has room.
// Reset (synchronous): registers to defaults, all slots free, queue and output empty.
// No clearing pass: slot memories are only read behind a per-slot valid bit.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_log_rate_limiter_unit import swl_pkg::*; #(
  parameter int USER_SLOTS = UserSlotsDefault,
  parameter int MAX_DEPTH  = MaxDepthDefault,
  parameter int TIME_BITS  = TimeBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_ready;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // write registers on the access cycle; only legal while the block is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_seconds <= WindowReset;
      cfg.max_requests   <= MaxReqReset;
      cfg.idle_timeout   <= IdleReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WINDOW: cfg.window_seconds <= pwdata[15:0];
        REG_MAXREQ: cfg.max_requests   <= pwdata[4:0];
        REG_IDLE:   cfg.idle_timeout   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW: prdata = 32'(cfg.window_seconds);
      REG_MAXREQ: prdata = 32'(cfg.max_requests);
      REG_IDLE:   prdata = 32'(cfg.idle_timeout);
      default:    prdata = '0;
    endcase
  end

  // classify and queue each request
  swl_front #(
    .USER_SLOTS(USER_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // evict, decide and sweep against the slot memories
  swl_back #(
    .USER_SLOTS(USER_SLOTS),
    .MAX_DEPTH (MAX_DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .cfg      (cfg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule
`default_nettype wire
